// ===== sv/hsl_pkg.sv =====
// shared constants and types for the hsl/hsv to rgb converter
// no dependencies; used by the converter, hue path and chroma path through scoped names
package hsl_pkg;

   localparam int FRACTION_BITS_DEFAULT = 12;

   // pipeline shape: three stages in the hue and chroma paths, three after them
   localparam int PATH_STAGES = 3;
   localparam int PIPE_STAGES = 6;

   // hue in 1/64 degree
   localparam int HUE_SECTOR = 3840;
   localparam int HUE_FULL   = 23040;
   // six full turns, makes every 18-bit hue non-negative
   localparam int HUE_OFFSET = 138240;

   // reciprocals for exact floor division of small values
   localparam logic [10:0] RECIP_45 = 11'd1457;
   localparam logic [12:0] RECIP_15 = 13'd4370;

   // width of the hue wrap result, of the angle within one turn and of the hue weight k
   localparam int WRAP_W = 19;
   localparam int ANGLE_W = 15;
   localparam int WEIGHT_W = 12;
   // per-channel level before the divide by 15
   localparam int LEVEL_W = 12;
   localparam int LEVEL_MAX = 3840;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

   localparam logic COLOR_MODEL_HSL = 1'b0;
   localparam logic COLOR_MODEL_HSV = 1'b1;

endpackage

// ===== sv/hsl_hsv_to_rgb_converter.sv =====
// HSL/HSV to RGB converter, six-stage pipeline taking one item per clock while
// the output is not held. The stage split follows the two multiplier stages of
// the hue wrap and chroma, the x-term multiplier and the final exact divide
// by 15. The pipeline stalls stage by stage from the output back, so bubbles
// are squeezed out and req_ready only drops when all six stages hold items.
// csr_write_data selects HSL (0) or HSV (1) and must only change while the
// pipeline is empty. Hue is in 1/64 degree and wraps modulo 360 degrees;
// saturation and lightness/value are Q1.FRACTION_BITS, clamped to 0..1.
// Depends on hsl_pkg, hsl_pipe_ctrl, hsl_hue_path and hsl_chroma_path.
module hsl_hsv_to_rgb_converter #(
   parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [17:0] req_hue,
   input  logic signed [13:0] req_saturation,
   input  logic signed [13:0] req_lightness_or_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);

   localparam int CW = 2 * FRACTION_BITS + 1;
   localparam int BW = 2 * FRACTION_BITS + 2;
   localparam int XW = 2 * FRACTION_BITS + 13;
   localparam int NW = 2 * FRACTION_BITS + 14;
   localparam int LW = hsl_pkg::LEVEL_W;
   localparam int WW = hsl_pkg::WEIGHT_W;

   logic                              color_model_ff;
   logic [hsl_pkg::PIPE_STAGES-1:0]   stage_en;
   logic [hsl_pkg::PIPE_STAGES-1:0]   stage_valid;

   hsl_pkg::sector_type               sector3;
   logic [WW-1:0]                     weight3;
   logic [CW-1:0]                     cn3;
   logic [BW-1:0]                     bias3;

   hsl_pkg::sector_type               sector4_ff;
   logic [XW-1:0]                     x4_ff, x4_in;
   logic [CW-1:0]                     cn4_ff;
   logic [BW-1:0]                     bias4_ff;

   logic [NW-1:0]                     base_term;
   logic [NW-1:0]                     c_term;
   logic [NW-1:0]                     x_term;
   logic [NW-1:0]                     term_r, term_g, term_b;
   logic [NW-1:0]                     sum_r, sum_g, sum_b;
   logic [LW-1:0]                     q_r_ff, q_g_ff, q_b_ff;
   logic [LW-1:0]                     q_r_in, q_g_in, q_b_in;

   logic [7:0]                        red_ff, green_ff, blue_ff;
   logic [7:0]                        red_in, green_in, blue_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_model_ff <= hsl_pkg::COLOR_MODEL_HSL;
      end else if (csr_write_enable) begin
         color_model_ff <= csr_write_data;
      end
   end

   hsl_pipe_ctrl #(
      .STAGES (hsl_pkg::PIPE_STAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .out_ready   (rsp_ready),
      .stage_en    (stage_en),
      .stage_valid (stage_valid)
   );

   hsl_hue_path u_hue (
      .clock    (clock),
      .stage_en (stage_en[hsl_pkg::PATH_STAGES-1:0]),
      .hue      (req_hue),
      .sector   (sector3),
      .weight   (weight3)
   );

   hsl_chroma_path #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_chroma (
      .clock              (clock),
      .stage_en           (stage_en[hsl_pkg::PATH_STAGES-1:0]),
      .color_model        (color_model_ff),
      .saturation         (req_saturation),
      .lightness_or_value (req_lightness_or_value),
      .chroma             (cn3),
      .bias               (bias3)
   );

   // stage 4: x term = cn * k
   assign x4_in = XW'(cn3) * XW'(weight3);

   // stage 5: level = 3840*b + 2*term, then drop 2*fraction_bits+1 bits
   always_comb begin
      base_term = (NW'(bias4_ff) << 12) - (NW'(bias4_ff) << 8);
      c_term    = (NW'(cn4_ff) << 13) - (NW'(cn4_ff) << 9);
      x_term    = NW'(x4_ff) << 1;
      case (sector4_ff)
         hsl_pkg::SEC_RED_YELLOW: begin
            term_r = c_term; term_g = x_term; term_b = '0;
         end
         hsl_pkg::SEC_YELLOW_GREEN: begin
            term_r = x_term; term_g = c_term; term_b = '0;
         end
         hsl_pkg::SEC_GREEN_CYAN: begin
            term_r = '0; term_g = c_term; term_b = x_term;
         end
         hsl_pkg::SEC_CYAN_BLUE: begin
            term_r = '0; term_g = x_term; term_b = c_term;
         end
         hsl_pkg::SEC_BLUE_MAGENTA: begin
            term_r = x_term; term_g = '0; term_b = c_term;
         end
         default: begin
            term_r = c_term; term_g = '0; term_b = x_term;
         end
      endcase
      sum_r  = base_term + term_r;
      sum_g  = base_term + term_g;
      sum_b  = base_term + term_b;
      q_r_in = sum_r[2*FRACTION_BITS+LW:2*FRACTION_BITS+1];
      q_g_in = sum_g[2*FRACTION_BITS+LW:2*FRACTION_BITS+1];
      q_b_in = sum_b[2*FRACTION_BITS+LW:2*FRACTION_BITS+1];
   end

   // stage 6: floor(q / 15), saturated at 255
   function automatic logic [7:0] to_byte(input logic [LW-1:0] q);
      logic [24:0] prod;
      logic [8:0]  scaled;
      prod   = 25'(q) * 25'(hsl_pkg::RECIP_15);
      scaled = prod[24:16];
      return scaled[8] ? 8'hff : scaled[7:0];
   endfunction

   assign red_in   = to_byte(q_r_ff);
   assign green_in = to_byte(q_g_ff);
   assign blue_in  = to_byte(q_b_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sector4_ff <= sector3;
         x4_ff      <= x4_in;
         cn4_ff     <= cn3;
         bias4_ff   <= bias3;
      end
      if (stage_en[4]) begin
         q_r_ff <= q_r_in;
         q_g_ff <= q_g_in;
         q_b_ff <= q_b_in;
      end
      if (stage_en[5]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = stage_valid[hsl_pkg::PIPE_STAGES-1];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // the input only backs up when every stage holds an item and the output waits
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid == '1) && !rsp_ready)
      else $error("input stalled with a free pipeline stage");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> (stage_valid == '0))
      else $error("pipeline not empty after reset");

   // hue weight never exceeds one sector
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      stage_valid[2] |-> (weight3 <= WW'(hsl_pkg::HUE_SECTOR)))
      else $error("hue weight above one sector");

   // a channel level is at most full scale (256 * 15)
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      stage_valid[4] |-> (q_r_ff <= LW'(hsl_pkg::LEVEL_MAX))
                      && (q_g_ff <= LW'(hsl_pkg::LEVEL_MAX))
                      && (q_b_ff <= LW'(hsl_pkg::LEVEL_MAX)))
      else $error("channel level above full scale");

endmodule

// ===== sv/hsl_pipe_ctrl.sv =====
// valid bits and per-stage load enables of the converter pipeline
// a stage loads when it is empty or the stage after it moves; uses no package
module hsl_pipe_ctrl #(
   parameter int STAGES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              out_ready,
   output logic [STAGES-1:0] stage_en,
   output logic [STAGES-1:0] stage_valid
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready_chain;

   always_comb begin
      ready_chain[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         ready_chain[i] = !valid_ff[i] || ready_chain[i+1];
      end
   end

   assign stage_en    = ready_chain[STAGES-1:0];
   assign in_ready    = ready_chain[0];
   assign stage_valid = valid_ff;
   assign valid_in    = {valid_ff[STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

endmodule

// ===== sv/hsl_hue_path.sv =====
// hue path: wrap into one turn, find the 60 degree sector and the weight of x
// depends on hsl_pkg for hue constants and the sector type
module hsl_hue_path (
   input  logic                                clock,
   input  logic [hsl_pkg::PATH_STAGES-1:0]     stage_en,
   input  logic signed [17:0]                  hue,
   output hsl_pkg::sector_type                 sector,
   output logic [hsl_pkg::WEIGHT_W-1:0]        weight
);

   logic [hsl_pkg::WRAP_W-1:0]   wrap_ff, wrap_in;
   logic [3:0]                   turns_ff, turns_in;
   logic [9:0]                   coarse;
   logic [20:0]                  turns_prod;
   logic [hsl_pkg::ANGLE_W-1:0]  angle_ff, angle_in;
   hsl_pkg::sector_type          sector_ff, sector_in;
   logic [hsl_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [12:0]                  phase;
   logic [12:0]                  phase_base;
   logic [hsl_pkg::WEIGHT_W-1:0] fold;

   // stage 1: offset to non-negative, turns = floor(wrap / 23040) via wrap/512/45
   always_comb begin
      wrap_in    = hsl_pkg::WRAP_W'(32'(hue) + hsl_pkg::HUE_OFFSET);
      coarse     = wrap_in[18:9];
      turns_prod = 21'(coarse) * 21'(hsl_pkg::RECIP_45);
      turns_in   = turns_prod[19:16];
   end

   // stage 2: angle within one turn
   assign angle_in = hsl_pkg::ANGLE_W'(wrap_ff
                     - hsl_pkg::WRAP_W'(turns_ff) * hsl_pkg::WRAP_W'(hsl_pkg::HUE_FULL));

   // stage 3: sector and the triangle weight k = 3840 - |t - 3840|
   always_comb begin
      if (angle_ff < hsl_pkg::ANGLE_W'(hsl_pkg::HUE_SECTOR)) begin
         sector_in = hsl_pkg::SEC_RED_YELLOW;
      end else if (angle_ff < hsl_pkg::ANGLE_W'(2 * hsl_pkg::HUE_SECTOR)) begin
         sector_in = hsl_pkg::SEC_YELLOW_GREEN;
      end else if (angle_ff < hsl_pkg::ANGLE_W'(3 * hsl_pkg::HUE_SECTOR)) begin
         sector_in = hsl_pkg::SEC_GREEN_CYAN;
      end else if (angle_ff < hsl_pkg::ANGLE_W'(4 * hsl_pkg::HUE_SECTOR)) begin
         sector_in = hsl_pkg::SEC_CYAN_BLUE;
      end else if (angle_ff < hsl_pkg::ANGLE_W'(5 * hsl_pkg::HUE_SECTOR)) begin
         sector_in = hsl_pkg::SEC_BLUE_MAGENTA;
      end else begin
         sector_in = hsl_pkg::SEC_MAGENTA_RED;
      end
      case (sector_in)
         hsl_pkg::SEC_RED_YELLOW, hsl_pkg::SEC_YELLOW_GREEN: begin
            phase_base = 13'd0;
         end
         hsl_pkg::SEC_GREEN_CYAN, hsl_pkg::SEC_CYAN_BLUE: begin
            phase_base = 13'(2 * hsl_pkg::HUE_SECTOR);
         end
         default: begin
            phase_base = 13'(4 * hsl_pkg::HUE_SECTOR);
         end
      endcase
      phase = 13'(angle_ff) - phase_base;
      if (phase >= 13'(hsl_pkg::HUE_SECTOR)) begin
         fold = hsl_pkg::WEIGHT_W'(phase - 13'(hsl_pkg::HUE_SECTOR));
      end else begin
         fold = hsl_pkg::WEIGHT_W'(13'(hsl_pkg::HUE_SECTOR) - phase);
      end
      weight_in = hsl_pkg::WEIGHT_W'(hsl_pkg::HUE_SECTOR) - fold;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         wrap_ff  <= wrap_in;
         turns_ff <= turns_in;
      end
      if (stage_en[1]) begin
         angle_ff <= angle_in;
      end
      if (stage_en[2]) begin
         sector_ff <= sector_in;
         weight_ff <= weight_in;
      end
   end

   assign sector = sector_ff;
   assign weight = weight_ff;

endmodule

// ===== sv/hsl_chroma_path.sv =====
// chroma path: clamp the fractions, form chroma cn and the bias term b
// depends on hsl_pkg for the color model codes
module hsl_chroma_path #(
   parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic [hsl_pkg::PATH_STAGES-1:0]     stage_en,
   input  logic                                color_model,
   input  logic signed [13:0]                  saturation,
   input  logic signed [13:0]                  lightness_or_value,
   output logic [2*FRACTION_BITS:0]            chroma,
   output logic [2*FRACTION_BITS+1:0]          bias
);

   localparam int FW  = FRACTION_BITS + 1;
   localparam int CW  = 2 * FRACTION_BITS + 1;
   localparam int BW  = 2 * FRACTION_BITS + 2;
   localparam int ONE = 1 << FRACTION_BITS;

   logic [FW-1:0]   sat_ff, sat_in;
   logic [FW-1:0]   lev_ff, lev_in;
   logic [FW-1:0]   lev2_ff;
   logic [FW:0]     twice_lev;
   logic [FW-1:0]   dev;
   logic [FW-1:0]   span;
   logic [FW-1:0]   mult_a;
   logic [2*FW-1:0] prod;
   logic [CW-1:0]   cn_ff, cn_in;
   logic [CW-1:0]   cn3_ff;
   logic [BW-1:0]   bias_ff, bias_in;

   function automatic logic [FW-1:0] clamp_frac(input logic signed [13:0] v);
      if (v < 0) begin
         return '0;
      end else if (32'(v) > ONE) begin
         return FW'(ONE);
      end else begin
         return FW'(v);
      end
   endfunction

   assign sat_in = clamp_frac(saturation);
   assign lev_in = clamp_frac(lightness_or_value);

   // hsl: cn = (1 - |2l - 1|) * s, hsv: cn = v * s
   always_comb begin
      twice_lev = {lev_ff, 1'b0};
      if (twice_lev >= (FW+1)'(ONE)) begin
         dev = FW'(twice_lev - (FW+1)'(ONE));
      end else begin
         dev = FW'((FW+1)'(ONE) - twice_lev);
      end
      span   = FW'(ONE) - dev;
      mult_a = (color_model == hsl_pkg::COLOR_MODEL_HSV) ? lev_ff : span;
      prod   = (2*FW)'(mult_a) * (2*FW)'(sat_ff);
      cn_in  = prod[CW-1:0];
   end

   // bias scaled by 2 * one^2 (3840 is applied in stage 5): hsl 2*l*one - cn, hsv 2*l*one - 2*cn
   assign bias_in = (BW'(lev2_ff) << (FRACTION_BITS + 1))
                  - ((color_model == hsl_pkg::COLOR_MODEL_HSV) ? (BW'(cn_ff) << 1)
                                                               : BW'(cn_ff));

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sat_ff <= sat_in;
         lev_ff <= lev_in;
      end
      if (stage_en[1]) begin
         cn_ff   <= cn_in;
         lev2_ff <= lev_ff;
      end
      if (stage_en[2]) begin
         cn3_ff  <= cn_ff;
         bias_ff <= bias_in;
      end
   end

   assign chroma = cn3_ff;
   assign bias   = bias_ff;

endmodule

// ===== dv/tb_hsl_hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// testbench for hsl_hsv_to_rgb_converter: a directed color table, then random colors
// in both color models, each item checked against its table pixel or a predictor kept in this file
// depends on hsl_pkg and the converter rtl
module tb_hsl_hsv_to_rgb_converter;

   localparam int FRAC_BITS = hsl_pkg::FRACTION_BITS_DEFAULT;
   localparam int FRAC_ONE = 1 << FRAC_BITS;
   localparam int STALL_MAX = 14;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_PER_PHASE = 260;
   localparam int RANDOM_PHASES = 4;
   localparam int NUM_ROWS = 25;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct {
      logic      mdl;
      int        hue;
      int        sat;
      int        lev;
      bit        known;
      pixel_type px;
   } color_row_type;

   // hue in 1/64 degree, fractions with 4096 = 1.0
   color_row_type color_rows [NUM_ROWS] = '{
      '{hsl_pkg::COLOR_MODEL_HSL, 0, 4096, 2048, 1'b1, 24'hff0000},
      '{hsl_pkg::COLOR_MODEL_HSL, 3840, 4096, 2048, 1'b1, 24'hffff00},
      '{hsl_pkg::COLOR_MODEL_HSL, 7680, 4096, 2048, 1'b1, 24'h00ff00},
      '{hsl_pkg::COLOR_MODEL_HSL, 15360, 4096, 2048, 1'b1, 24'h0000ff},
      '{hsl_pkg::COLOR_MODEL_HSL, -23040, 4096, 2048, 1'b1, 24'hff0000},
      '{hsl_pkg::COLOR_MODEL_HSL, 0, 0, 2048, 1'b1, 24'h808080},
      '{hsl_pkg::COLOR_MODEL_HSL, 0, -8192, 2048, 1'b1, 24'h808080},
      '{hsl_pkg::COLOR_MODEL_HSL, 0, 8191, 2048, 1'b1, 24'hff0000},
      '{hsl_pkg::COLOR_MODEL_HSL, 5000, 4096, 0, 1'b1, 24'h000000},
      '{hsl_pkg::COLOR_MODEL_HSL, 5000, 4096, 4096, 1'b1, 24'hffffff},
      '{hsl_pkg::COLOR_MODEL_HSL, 5000, 3000, -8192, 1'b1, 24'h000000},
      '{hsl_pkg::COLOR_MODEL_HSL, 5000, 3000, 8191, 1'b1, 24'hffffff},
      '{hsl_pkg::COLOR_MODEL_HSL, 131071, 4096, 2048, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSL, -131072, 4096, 2048, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSL, 3839, 4096, 2048, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSL, 23039, 3000, 1500, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSL, 11520, 2500, 3000, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSL, 19200, 4096, 1024, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSV, 0, 4096, 4096, 1'b1, 24'hff0000},
      '{hsl_pkg::COLOR_MODEL_HSV, 7680, 0, 4096, 1'b1, 24'hffffff},
      '{hsl_pkg::COLOR_MODEL_HSV, 7680, 4096, 0, 1'b1, 24'h000000},
      '{hsl_pkg::COLOR_MODEL_HSV, 23040, 4096, 4096, 1'b1, 24'hff0000},
      '{hsl_pkg::COLOR_MODEL_HSV, 9000, 2000, 3000, 1'b0, 24'h0},
      '{hsl_pkg::COLOR_MODEL_HSV, -1, 8191, -1, 1'b1, 24'h000000},
      '{hsl_pkg::COLOR_MODEL_HSV, 11519, 3500, 2500, 1'b0, 24'h0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic               csr_write_data = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [17:0] req_hue = '0;
   logic signed [13:0] req_saturation = '0;
   logic signed [13:0] req_lightness_or_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_red;
   logic [7:0]         rsp_green;
   logic [7:0]         rsp_blue;

   pixel_type expected_pixels [$];
   logic      color_model_now = hsl_pkg::COLOR_MODEL_HSL;
   bit        send_calm = 1'b0;
   int        mismatches = 0;

   hsl_hsv_to_rgb_converter #(.FRACTION_BITS(FRAC_BITS)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_hue                (req_hue),
      .req_saturation         (req_saturation),
      .req_lightness_or_value (req_lightness_or_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_red                (rsp_red),
      .rsp_green              (rsp_green),
      .rsp_blue               (rsp_blue)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned clamp_unit(logic signed [13:0] v);
      longint x;
      x = v;
      if (x < 0) return 0;
      if (x > FRAC_ONE) return FRAC_ONE;
      return x;
   endfunction

   // all terms scaled by 2 * one * one * 3840 so the only rounding is the final floor
   function automatic pixel_type hsx_to_rgb(logic signed [17:0] hue, logic signed [13:0] sat,
                                            logic signed [13:0] lev, logic mdl);
      longint unsigned     one, denom, s, l, hw, t, fold, k, cn, mm, cc, xx, twol, absd, q;
      longint unsigned     lvl [3];
      logic [7:0]          ch [3];
      longint              hr;
      hsl_pkg::sector_type sec;
      int                  i;
      one = FRAC_ONE;
      denom = 2 * one * one * hsl_pkg::HUE_SECTOR;
      s = clamp_unit(sat);
      l = clamp_unit(lev);
      hr = longint'(hue) % hsl_pkg::HUE_FULL;
      if (hr < 0) hr += hsl_pkg::HUE_FULL;
      hw = hr;
      sec = hsl_pkg::sector_type'(hw / hsl_pkg::HUE_SECTOR);
      t = hw % (2 * hsl_pkg::HUE_SECTOR);
      fold = (t >= hsl_pkg::HUE_SECTOR) ? (t - hsl_pkg::HUE_SECTOR)
                                        : (hsl_pkg::HUE_SECTOR - t);
      k = hsl_pkg::HUE_SECTOR - fold;
      if (mdl == hsl_pkg::COLOR_MODEL_HSL) begin
         twol = 2 * l;
         absd = (twol >= one) ? (twol - one) : (one - twol);
         cn = (one - absd) * s;
         mm = l * one * (2 * hsl_pkg::HUE_SECTOR) - cn * hsl_pkg::HUE_SECTOR;
      end else begin
         cn = l * s;
         mm = l * one * (2 * hsl_pkg::HUE_SECTOR) - cn * (2 * hsl_pkg::HUE_SECTOR);
      end
      cc = cn * (2 * hsl_pkg::HUE_SECTOR);
      xx = cn * 2 * k;
      case (sec)
         hsl_pkg::SEC_RED_YELLOW:   lvl = '{cc, xx, 64'd0};
         hsl_pkg::SEC_YELLOW_GREEN: lvl = '{xx, cc, 64'd0};
         hsl_pkg::SEC_GREEN_CYAN:   lvl = '{64'd0, cc, xx};
         hsl_pkg::SEC_CYAN_BLUE:    lvl = '{64'd0, xx, cc};
         hsl_pkg::SEC_BLUE_MAGENTA: lvl = '{xx, 64'd0, cc};
         default:                   lvl = '{cc, 64'd0, xx};
      endcase
      for (i = 0; i < 3; i++) begin
         q = ((lvl[i] + mm) * 256) / denom;
         ch[i] = (q > 255) ? 8'hff : q[7:0];
      end
      return '{ch[0], ch[1], ch[2]};
   endfunction

   function automatic logic signed [13:0] random_fraction();
      case ($urandom_range(0, 5))
         0: return 14'($urandom);
         1: return 14'sd0;
         2: return 14'(FRAC_ONE);
         default: return 14'($urandom_range(0, FRAC_ONE));
      endcase
   endfunction

   task automatic send_color(input logic signed [17:0] hue, input logic signed [13:0] sat,
                             input logic signed [13:0] lev, input bit known,
                             input pixel_type typed);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hue <= hue;
      req_saturation <= sat;
      req_lightness_or_value <= lev;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(known ? typed : hsx_to_rgb(hue, sat, lev, color_model_now));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // the model select may only change with the pipeline empty
   task automatic write_color_model(input logic mdl);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= mdl;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      color_model_now = mdl;
   endtask

   task automatic check_pixel(input pixel_type got);
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected item: rgb %0d %0d %0d", got.red, got.green, got.blue);
      end else begin
         want = expected_pixels.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                        want.red, want.green, want.blue, got.red, got.green, got.blue);
         end
      end
   endtask

   initial begin : result_side
      int gap;
      bit calm;
      calm = 1'b0;
      wait (!reset);
      forever begin
         gap = calm ? 0 : $urandom_range(0, STALL_MAX);
         if ($urandom_range(0, 39) == 0) calm = !calm;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_pixel('{rsp_red, rsp_green, rsp_blue});
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic signed [17:0] hue;
      logic signed [13:0] sat;
      logic signed [13:0] lev;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_color_model(hsl_pkg::COLOR_MODEL_HSL);
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (color_rows[r].mdl !== color_model_now) write_color_model(color_rows[r].mdl);
         send_color(18'(color_rows[r].hue), 14'(color_rows[r].sat), 14'(color_rows[r].lev),
                    color_rows[r].known, color_rows[r].px);
      end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_color_model(p[0] ? hsl_pkg::COLOR_MODEL_HSV : hsl_pkg::COLOR_MODEL_HSL);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            // hold off once per phase until the pipeline has emptied
            if (i == RANDOM_PER_PHASE / 2) wait_drained();
            case ($urandom_range(0, 3))
               0: hue = 18'($urandom);
               3: hue = 18'(int'($urandom_range(0, 6)) * hsl_pkg::HUE_SECTOR
                            + int'($urandom_range(0, 2)) - 1);
               default: hue = 18'($urandom_range(0, hsl_pkg::HUE_FULL - 1));
            endcase
            sat = random_fraction();
            lev = random_fraction();
            send_color(hue, sat, lev, 1'b0, '0);
         end
      end
      wait_drained();
      repeat (4 * hsl_pkg::PIPE_STAGES) @(posedge clock);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== hsl_hsv_to_rgb_converter.f =====
sv/hsl_pkg.sv
sv/hsl_pipe_ctrl.sv
sv/hsl_hue_path.sv
sv/hsl_chroma_path.sv
sv/hsl_hsv_to_rgb_converter.sv
dv/tb_hsl_hsv_to_rgb_converter.sv
